// ----- sv/tht_pkg.sv -----
// Shared types, constants and helpers for the touch hit-test table.
// No dependencies; used by tht_div, tht_table, the top module and the testbench.
`default_nettype none

package tht_pkg;

  // Table geometry
  localparam int MAX_QUADS = 64;
  localparam int IDX_W     = $clog2(MAX_QUADS);
  localparam int CNT_W     = $clog2(MAX_QUADS + 1);
  localparam int ENTRY_W   = 7;

  // Request kinds
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CAM_X    = 3'd0;
  localparam logic [2:0] REG_CAM_Y    = 3'd1;
  localparam logic [2:0] REG_ZOOM     = 3'd2;
  localparam logic [2:0] REG_HALF_W   = 3'd3;
  localparam logic [2:0] REG_HALF_H   = 3'd4;
  localparam logic [2:0] REG_MIN_HALF = 3'd5;

  // Stored quad
  typedef struct packed {
    logic [31:0]        entity;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] hw;
    logic signed [31:0] hh;
  } quad_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_M1,
    ST_A_M2,
    ST_A_DS,
    ST_A_DW,
    ST_A_WR,
    ST_Q_RD,
    ST_Q_MX,
    ST_Q_MY,
    ST_Q_MW,
    ST_Q_MH,
    ST_Q_HY,
    ST_Q_CMP,
    ST_DONE
  } state_t;

  // Divider status
  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_stat_t;

  // Saturate a 50-bit signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tht_mul.sv -----
// Shared unsigned 33x31 multiplier with a registered 64-bit product.
// No dependencies.
`default_nettype none

module tht_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [30:0] b,
  output logic      [63:0] p_r
);

  logic [63:0] p_nxt;

  // Form the product
  assign p_nxt = {31'b0, a} * {33'b0, b};

  // Register it
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/tht_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on tht_pkg for the status struct.
`default_nettype none

module tht_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [63:0]     dividend,
  input  wire logic [31:0]     divisor,
  output tht_pkg::div_stat_t   stat
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;
  logic        take;

  // Load on start, else one shift-subtract step while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[31:0], quo_r[63]};
    take     = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = 33'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = take ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt = {quo_r[62:0], take};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = quo_r;

endmodule

`default_nettype wire

// ----- sv/tht_table.sv -----
// Quad table memory: one write port, one registered read port.
// Depends on tht_pkg for the entry type and depth.
`default_nettype none

module tht_table (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [tht_pkg::IDX_W-1:0] waddr,
  input  wire tht_pkg::quad_t            wdata,
  input  wire logic                      re,
  input  wire logic [tht_pkg::IDX_W-1:0] raddr,
  output tht_pkg::quad_t                 rdata_r
);

  tht_pkg::quad_t mem [tht_pkg::MAX_QUADS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/touch_hit_test_table.sv -----
// Touch hit-test table: clear, plain append, textured append (two 64-step divisions)
// and query, which steps each scanned entry through a read, four multiplies and a compare.
// One request at a time; the multiplier is shared and the divider is bit-serial.
// A finished result waits in an output register while the next request is taken.
// Synchronous active-low reset empties the table and loads the camera defaults.
// Depends on tht_pkg, tht_mul, tht_div and tht_table.
`default_nettype none

module touch_hit_test_table (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request: entity_id[31:0] pos_x[63:32] pos_y[95:64] scale_x[126:96]
  // scale_y[157:127] tex_width_px[173:158] tex_height_px[189:174]
  // u_span[207:190] v_span[225:208] pixels_per_unit[256:226] touch_radius[285:257]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [287:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // mode[1:0]
  // result: hit_found[0] hit_entity[32:1] table_full[33] entry_count[40:34]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers
  logic signed [31:0] cam_x_r, cam_y_r;
  logic [30:0]        zoom_r;
  logic [28:0]        half_w_r, half_h_r, min_half_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // Sequencer and item registers
  tht_pkg::state_t    state_r, state_nxt;
  logic [1:0]         mode_r;
  logic [31:0]        ent_r;
  logic signed [31:0] px_r, py_r;
  logic [30:0]        sx_r, sy_r, ppu_r;
  logic [15:0]        tw_r, th_r;
  logic signed [17:0] us_r, vs_r;
  logic [28:0]        rad_r;
  logic               accept;

  logic [tht_pkg::CNT_W-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic               axis_r, axis_nxt;
  logic signed [31:0] hw_r, hw_nxt, hh_r, hh_nxt;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, hx_r, hx_nxt, hy_r, hy_nxt;
  logic               neg_r, neg_nxt;
  logic               found_r, found_nxt, full_r, full_nxt;
  logic [31:0]        hitent_r, hitent_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        out_data_r, out_data_nxt;

  // Shared units
  logic [32:0]        mul_a;
  logic [30:0]        mul_b;
  logic [63:0]        mul_p;
  logic               div_start;
  logic [31:0]        div_den;
  tht_pkg::div_stat_t div_stat;
  logic               mem_we, mem_re;
  logic [tht_pkg::IDX_W-1:0] mem_raddr;
  tht_pkg::quad_t     mem_wdata, rd;

  // Datapath helpers
  logic               textured;
  logic signed [17:0] span;
  logic [17:0]        span_mag;
  logic [15:0]        tex_cur;
  logic [30:0]        scale_cur;
  logic [31:0]        qsat;
  logic signed [31:0] half_tex;
  logic [47:0]        pq;
  logic signed [49:0] pv;
  logic signed [32:0] dcx, dcy, ddx, ddy;
  logic [32:0]        adx, ady;
  logic [33:0]        limx, limy;
  logic signed [31:0] hsat;
  logic               hit;

  tht_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  tht_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(mul_p), .divisor(div_den), .stat(div_stat)
  );

  tht_table u_table (
    .clk(clk), .we(mem_we), .waddr(count_r[tht_pkg::IDX_W-1:0]), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata_r(rd)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      tht_pkg::REG_CAM_X:    cfg_prdata = cam_x_r;
      tht_pkg::REG_CAM_Y:    cfg_prdata = cam_y_r;
      tht_pkg::REG_ZOOM:     cfg_prdata = {1'b0, zoom_r};
      tht_pkg::REG_HALF_W:   cfg_prdata = {3'b0, half_w_r};
      tht_pkg::REG_HALF_H:   cfg_prdata = {3'b0, half_h_r};
      tht_pkg::REG_MIN_HALF: cfg_prdata = {3'b0, min_half_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r    <= 32'sd0;
      cam_y_r    <= 32'sd0;
      zoom_r     <= 31'd65536;
      half_w_r   <= 29'd32768;
      half_h_r   <= 29'd32768;
      min_half_r <= 29'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tht_pkg::REG_CAM_X:    cam_x_r    <= cfg_pwdata;
        tht_pkg::REG_CAM_Y:    cam_y_r    <= cfg_pwdata;
        tht_pkg::REG_ZOOM:     zoom_r     <= cfg_pwdata[30:0];
        tht_pkg::REG_HALF_W:   half_w_r   <= cfg_pwdata[28:0];
        tht_pkg::REG_HALF_H:   half_h_r   <= cfg_pwdata[28:0];
        tht_pkg::REG_MIN_HALF: min_half_r <= cfg_pwdata[28:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_tready  = (state_r == tht_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_tuser;
      ent_r  <= in_tdata[31:0];
      px_r   <= in_tdata[63:32];
      py_r   <= in_tdata[95:64];
      sx_r   <= in_tdata[126:96];
      sy_r   <= in_tdata[157:127];
      tw_r   <= in_tdata[173:158];
      th_r   <= in_tdata[189:174];
      us_r   <= in_tdata[207:190];
      vs_r   <= in_tdata[225:208];
      ppu_r  <= in_tdata[256:226];
      rad_r  <= in_tdata[285:257];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tht_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tht_pkg::ST_DONE;
          if (in_tuser == tht_pkg::MODE_APPEND &&
              count_r < tht_pkg::CNT_W'(tht_pkg::MAX_QUADS)) begin
            if (in_tdata[173:158] != 16'd0 && in_tdata[189:174] != 16'd0) begin
              state_nxt = tht_pkg::ST_A_M1;
            end else begin
              state_nxt = tht_pkg::ST_A_WR;
            end
          end else if (in_tuser == tht_pkg::MODE_QUERY && count_r != '0) begin
            state_nxt = tht_pkg::ST_Q_RD;
          end
        end
      end
      tht_pkg::ST_A_M1: state_nxt = tht_pkg::ST_A_M2;
      tht_pkg::ST_A_M2: state_nxt = tht_pkg::ST_A_DS;
      tht_pkg::ST_A_DS: state_nxt = tht_pkg::ST_A_DW;
      tht_pkg::ST_A_DW: begin
        if (div_stat.done) begin
          state_nxt = axis_r ? tht_pkg::ST_A_WR : tht_pkg::ST_A_M1;
        end
      end
      tht_pkg::ST_A_WR:  state_nxt = tht_pkg::ST_DONE;
      tht_pkg::ST_Q_RD:  state_nxt = tht_pkg::ST_Q_MX;
      tht_pkg::ST_Q_MX:  state_nxt = tht_pkg::ST_Q_MY;
      tht_pkg::ST_Q_MY:  state_nxt = tht_pkg::ST_Q_MW;
      tht_pkg::ST_Q_MW:  state_nxt = tht_pkg::ST_Q_MH;
      tht_pkg::ST_Q_MH:  state_nxt = tht_pkg::ST_Q_HY;
      tht_pkg::ST_Q_HY:  state_nxt = tht_pkg::ST_Q_CMP;
      tht_pkg::ST_Q_CMP: begin
        if (hit || idx_r == '0) begin
          state_nxt = tht_pkg::ST_DONE;
        end else begin
          state_nxt = tht_pkg::ST_Q_RD;
        end
      end
      tht_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = tht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tht_pkg::ST_IDLE;
    endcase
  end

  // Shared datapath terms
  always_comb begin
    textured  = (tw_r != 16'd0) && (th_r != 16'd0);
    span      = axis_r ? vs_r : us_r;
    span_mag  = span[17] ? 18'(-span) : span;
    tex_cur   = axis_r ? th_r : tw_r;
    scale_cur = axis_r ? sy_r : sx_r;
    div_den   = {(ppu_r == 31'd0) ? 31'd65536 : ppu_r, 1'b0};
    qsat      = (div_stat.quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_stat.quot[31:0];
    half_tex  = span[17] ? -$signed(qsat) : $signed(qsat);
    pq        = mul_p[63:16];
    pv        = neg_r ? -$signed({2'b00, pq}) : $signed({2'b00, pq});
    hsat      = tht_pkg::sat32(pv);
    dcx       = $signed({rd.cx[31], rd.cx}) - $signed({cam_x_r[31], cam_x_r});
    dcy       = $signed({rd.cy[31], rd.cy}) - $signed({cam_y_r[31], cam_y_r});
    ddx       = $signed({px_r[31], px_r}) - $signed({cx_r[31], cx_r});
    ddy       = $signed({py_r[31], py_r}) - $signed({cy_r[31], cy_r});
    adx       = ddx[32] ? 33'(-ddx) : ddx;
    ady       = ddy[32] ? 33'(-ddy) : ddy;
    limx      = {2'b00, hx_r} + {5'b0, rad_r};
    limy      = {2'b00, hy_r} + {5'b0, rad_r};
    hit       = ({1'b0, adx} <= limx) && ({1'b0, ady} <= limy);
  end

  // Unit controls and register updates
  always_comb begin
    mul_a         = 33'd0;
    mul_b         = zoom_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[tht_pkg::IDX_W-1:0];
    mem_wdata     = '{entity: ent_r, cx: px_r, cy: py_r, hw: hw_r, hh: hh_r};
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    axis_nxt      = axis_r;
    hw_nxt        = hw_r;
    hh_nxt        = hh_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    neg_nxt       = neg_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    hitent_nxt    = hitent_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      tht_pkg::ST_IDLE: begin
        // start a request
        found_nxt  = 1'b0;
        full_nxt   = 1'b0;
        hitent_nxt = 32'd0;
        axis_nxt   = 1'b0;
        idx_nxt    = count_r;
        hw_nxt     = {2'b0, in_tdata[126:97]};
        hh_nxt     = {2'b0, in_tdata[157:128]};
        if (accept) begin
          if (in_tuser == tht_pkg::MODE_CLEAR) begin
            count_nxt = '0;
          end else if (in_tuser == tht_pkg::MODE_APPEND &&
                       count_r >= tht_pkg::CNT_W'(tht_pkg::MAX_QUADS)) begin
            full_nxt = 1'b1;
          end
        end
      end
      tht_pkg::ST_A_M1: begin
        // texels times UV span
        mul_a = {17'd0, tex_cur};
        mul_b = {13'd0, span_mag};
      end
      tht_pkg::ST_A_M2: begin
        // times scale
        mul_a = mul_p[32:0];
        mul_b = scale_cur;
      end
      tht_pkg::ST_A_DS: begin
        div_start = 1'b1;
      end
      tht_pkg::ST_A_DW: begin
        // land one half extent
        if (div_stat.done) begin
          if (axis_r) begin
            hh_nxt = half_tex;
          end else begin
            hw_nxt = half_tex;
          end
          axis_nxt = 1'b1;
        end
      end
      tht_pkg::ST_A_WR: begin
        mem_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        if (!textured) begin
          mem_wdata.hw = hw_r;
          mem_wdata.hh = hh_r;
        end
      end
      tht_pkg::ST_Q_RD: begin
        // step back one entry
        idx_nxt   = idx_r - 1'b1;
        mem_raddr = idx_nxt[tht_pkg::IDX_W-1:0];
        mem_re    = 1'b1;
      end
      tht_pkg::ST_Q_MX: begin
        mul_a   = dcx[32] ? 33'(-dcx) : dcx;
        neg_nxt = dcx[32];
      end
      tht_pkg::ST_Q_MY: begin
        cx_nxt  = tht_pkg::sat32($signed({21'd0, half_w_r}) + pv);
        mul_a   = dcy[32] ? 33'(-dcy) : dcy;
        neg_nxt = dcy[32];
      end
      tht_pkg::ST_Q_MW: begin
        cy_nxt  = tht_pkg::sat32($signed({21'd0, half_h_r}) - pv);
        mul_a   = rd.hw[31] ? {1'b0, -rd.hw} : {1'b0, rd.hw};
        neg_nxt = rd.hw[31];
      end
      tht_pkg::ST_Q_MH: begin
        hx_nxt  = (hsat < $signed({3'b0, min_half_r})) ? {3'b0, min_half_r} : hsat;
        mul_a   = rd.hh[31] ? {1'b0, -rd.hh} : {1'b0, rd.hh};
        neg_nxt = rd.hh[31];
      end
      tht_pkg::ST_Q_HY: begin
        hy_nxt = (hsat < $signed({3'b0, min_half_r})) ? {3'b0, min_half_r} : hsat;
      end
      tht_pkg::ST_Q_CMP: begin
        if (hit) begin
          found_nxt  = 1'b1;
          hitent_nxt = rd.entity;
        end
      end
      tht_pkg::ST_DONE: begin
        // hand the result to the output register
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, tht_pkg::ENTRY_W'(count_r), full_r, hitent_r, found_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tht_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    axis_r     <= axis_nxt;
    hw_r       <= hw_nxt;
    hh_r       <= hh_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    hx_r       <= hx_nxt;
    hy_r       <= hy_nxt;
    neg_r      <= neg_nxt;
    found_r    <= found_nxt;
    full_r     <= full_nxt;
    hitent_r   <= hitent_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tht_pkg::CNT_W'(tht_pkg::MAX_QUADS))
    else $error("entry count beyond table depth");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tht_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[33] |->
      out_data_r[40:34] == tht_pkg::ENTRY_W'(tht_pkg::MAX_QUADS))
    else $error("table full flagged below capacity");

endmodule

`default_nettype wire

// ----- tb/touch_hit_test_table_test.sv -----
// Self-checking testbench for the touch hit-test table: directed table plus random requests.
// Uses tht_pkg for request kinds, register indexes, quad type and depth; drives touch_hit_test_table only.
`default_nettype none

module touch_hit_test_table_test;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int N_RANDOM       = 1950;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  touch_hit_test_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct {
    logic [1:0]         mode;
    logic [31:0]        entity_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        scale_x;
    logic [30:0]        scale_y;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic signed [17:0] u_span;
    logic signed [17:0] v_span;
    logic [30:0]        ppu;
    logic [28:0]        radius;
  } touch_req_t;

  typedef struct {
    logic        hit_found;
    logic [31:0] hit_entity;
    logic        table_full;
    logic [6:0]  entry_count;
  } hit_result_t;

  // predictor state
  tht_pkg::quad_t        quads_mdl[tht_pkg::MAX_QUADS];
  int                    count_mdl;
  logic signed [31:0]    cam_x_mdl, cam_y_mdl;
  logic [30:0]           zoom_mdl;
  logic [28:0]           half_w_mdl, half_h_mdl, min_half_mdl;

  hit_result_t           pending_hits[$];
  int                    errors;
  int                    idle_cycles;
  bit                    calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $time);
    errors++;
  endtask

  // Q16.16 product truncated toward zero
  function automatic longint fix_mul(input longint a, input longint b);
    longint mag;
    mag = (a < 0) ? -a : a;
    mag = (mag * b) >>> 16;
    return (a < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [31:0] sprite_half(input logic [30:0] scale,
      input logic [15:0] tex, input logic signed [17:0] span, input logic [30:0] ppu,
      input bit textured);
    logic [127:0] prod;
    logic [127:0] q;
    logic [31:0]  mag;
    logic [17:0]  s;
    if (!textured) return {2'b0, scale[30:1]};
    s = span[17] ? -span : span;
    prod = 128'(scale) * 128'(tex) * 128'(s);
    q = prod / (128'(ppu) * 2);
    mag = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    return span[17] ? -$signed(mag) : $signed(mag);
  endfunction

  // work out the result of one request and update the table copy
  function automatic hit_result_t predict_hit(input touch_req_t r);
    hit_result_t res;
    longint cx, cy, hx, hy, dx, dy, mn, rad;
    logic [30:0] ppu;
    bit tex;
    res = '{1'b0, 32'd0, 1'b0, 7'd0};
    case (r.mode)
      tht_pkg::MODE_CLEAR: count_mdl = 0;
      tht_pkg::MODE_APPEND: begin
        if (count_mdl >= tht_pkg::MAX_QUADS) begin
          res.table_full = 1'b1;
        end else begin
          tex = (r.tex_w != 0) && (r.tex_h != 0);
          ppu = (r.ppu == 0) ? 31'd65536 : r.ppu;
          quads_mdl[count_mdl].entity = r.entity_id;
          quads_mdl[count_mdl].cx = r.pos_x;
          quads_mdl[count_mdl].cy = r.pos_y;
          quads_mdl[count_mdl].hw = sprite_half(r.scale_x, r.tex_w, r.u_span, ppu, tex);
          quads_mdl[count_mdl].hh = sprite_half(r.scale_y, r.tex_h, r.v_span, ppu, tex);
          count_mdl++;
        end
      end
      tht_pkg::MODE_QUERY: begin
        mn = min_half_mdl;
        rad = r.radius;
        for (int i = count_mdl - 1; i >= 0; i--) begin
          cx = clamp32(longint'(half_w_mdl) +
                       fix_mul(longint'(quads_mdl[i].cx) - cam_x_mdl, zoom_mdl));
          cy = clamp32(longint'(half_h_mdl) -
                       fix_mul(longint'(quads_mdl[i].cy) - cam_y_mdl, zoom_mdl));
          hx = clamp32(fix_mul(quads_mdl[i].hw, zoom_mdl));
          hy = clamp32(fix_mul(quads_mdl[i].hh, zoom_mdl));
          if (hx < mn) hx = mn;
          if (hy < mn) hy = mn;
          dx = longint'(r.pos_x) - cx;
          dy = longint'(r.pos_y) - cy;
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx <= hx + rad && dy <= hy + rad) begin
            res.hit_found = 1'b1;
            res.hit_entity = quads_mdl[i].entity;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = count_mdl[6:0];
    return res;
  endfunction

  // output side: random stall, compare each result with the oldest expectation
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    hit_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        report("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        e = pending_hits.pop_front();
        if (out_tdata[0] !== e.hit_found) report("hit_found", out_tdata[0], e.hit_found);
        if (out_tdata[32:1] !== e.hit_entity) report("hit_entity", out_tdata[32:1], e.hit_entity);
        if (out_tdata[33] !== e.table_full) report("table_full", out_tdata[33], e.table_full);
        if (out_tdata[40:34] !== e.entry_count)
          report("entry_count", out_tdata[40:34], e.entry_count);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      tht_pkg::REG_CAM_X:    cam_x_mdl = val;
      tht_pkg::REG_CAM_Y:    cam_y_mdl = val;
      tht_pkg::REG_ZOOM:     zoom_mdl = val[30:0];
      tht_pkg::REG_HALF_W:   half_w_mdl = val[28:0];
      tht_pkg::REG_HALF_H:   half_h_mdl = val[28:0];
      tht_pkg::REG_MIN_HALF: min_half_mdl = val[28:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(input logic [31:0] cx, input logic [31:0] cy,
      input logic [31:0] zm, input logic [31:0] hw, input logic [31:0] hh,
      input logic [31:0] mn);
    write_reg(tht_pkg::REG_CAM_X, cx);
    write_reg(tht_pkg::REG_CAM_Y, cy);
    write_reg(tht_pkg::REG_ZOOM, zm);
    write_reg(tht_pkg::REG_HALF_W, hw);
    write_reg(tht_pkg::REG_HALF_H, hh);
    write_reg(tht_pkg::REG_MIN_HALF, mn);
  endtask

  // send one request, optionally with a typed-in expectation
  task automatic send_request(input touch_req_t r, input bit typed, input hit_result_t typed_res);
    hit_result_t p;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {2'b0, r.radius, r.ppu, r.v_span, r.u_span, r.tex_h, r.tex_w,
                  r.scale_y, r.scale_x, r.pos_y, r.pos_x, r.entity_id};
    do @(posedge clk); while (!in_tready);
    p = predict_hit(r);
    pending_hits.insert(pending_hits.size(), typed ? typed_res : p);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic touch_req_t blank_req(input logic [1:0] m);
    touch_req_t r;
    r = '{m, 32'd0, 32'sd0, 32'sd0, 31'd0, 31'd0, 16'd0, 16'd0, 18'sd0, 18'sd0, 31'd0, 29'd0};
    return r;
  endfunction

  // random request; mostly appends of plausible quads and queries near them
  function automatic touch_req_t random_req(input bit wild);
    touch_req_t r;
    int k;
    r = blank_req(tht_pkg::MODE_APPEND);
    k = $urandom_range(99);
    r.mode = (k < 3) ? tht_pkg::MODE_CLEAR : (k < 5) ? tht_pkg::MODE_NOP :
             (k < 50) ? tht_pkg::MODE_APPEND : tht_pkg::MODE_QUERY;
    r.entity_id = $urandom;
    if (wild) begin
      r.pos_x = $urandom; r.pos_y = $urandom;
      r.scale_x = $urandom; r.scale_y = $urandom;
      r.radius = $urandom;
      r.ppu = $urandom;
    end else begin
      r.pos_x = $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
      r.pos_y = $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
      r.scale_x = $urandom_range(65536 * 16);
      r.scale_y = $urandom_range(65536 * 16);
      r.radius = $urandom_range(65536 * 8);
      r.ppu = ($urandom_range(3) == 0) ? 31'd0 : $urandom_range(65536 * 200);
    end
    if ($urandom_range(2) != 0) begin
      r.tex_w = $urandom; r.tex_h = $urandom;
      if ($urandom_range(9) == 0) r.tex_h = 16'd0;
    end
    r.u_span = $signed($urandom_range(131072)) - 65536;
    r.v_span = $signed($urandom_range(131072)) - 65536;
    return r;
  endfunction

  // directed table
  localparam int N_DIRECTED = 14;
  touch_req_t  dir_req[N_DIRECTED];
  bit          dir_typed[N_DIRECTED];
  hit_result_t dir_res[N_DIRECTED];

  task automatic build_directed();
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_typed[i] = 1'b0;
      dir_res[i] = '{1'b0, 32'd0, 1'b0, 7'd0};
    end
    // query on an empty table after reset: no hit
    dir_req[0] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[0].pos_x = 32'sh8000_0000; dir_req[0].radius = 29'h1FFF_FFFF;
    dir_typed[0] = 1'b1;
    // unused mode: count only
    dir_req[1] = blank_req(tht_pkg::MODE_NOP);
    dir_typed[1] = 1'b1;
    // plain quad at origin: all-ones entity and scales, texture width set but height zero
    dir_req[2] = blank_req(tht_pkg::MODE_APPEND);
    dir_req[2].entity_id = 32'hFFFF_FFFF; dir_req[2].scale_x = 31'h7FFF_FFFF;
    dir_req[2].scale_y = 31'h7FFF_FFFF; dir_req[2].tex_w = 16'hFFFF;
    dir_typed[2] = 1'b1; dir_res[2].entry_count = 7'd1;
    // textured sprite, extreme positions, largest scale_x and width, negative u span, ppu zero
    dir_req[3] = blank_req(tht_pkg::MODE_APPEND);
    dir_req[3].entity_id = 32'h1234_5678; dir_req[3].pos_x = 32'sh7FFF_FFFF;
    dir_req[3].pos_y = 32'sh8000_0000; dir_req[3].scale_x = 31'h7FFF_FFFF;
    dir_req[3].scale_y = 31'd65536; dir_req[3].tex_w = 16'hFFFF; dir_req[3].tex_h = 16'd1;
    dir_req[3].u_span = -18'sd65536; dir_req[3].v_span = 18'sd65536;
    // textured with largest ppu and small span
    dir_req[4] = blank_req(tht_pkg::MODE_APPEND);
    dir_req[4].entity_id = 32'h0000_00A5; dir_req[4].scale_x = 31'd131072;
    dir_req[4].scale_y = 31'd131072; dir_req[4].tex_w = 16'd32; dir_req[4].tex_h = 16'd32;
    dir_req[4].u_span = 18'sd1; dir_req[4].v_span = -18'sd1;
    dir_req[4].ppu = 31'h7FFF_FFFF;
    // queries: at screen center, far corner, with largest radius
    dir_req[5] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[5].pos_x = 32'sd32768; dir_req[5].pos_y = 32'sd32768;
    dir_req[6] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[6].pos_x = 32'sh7FFF_FFFF; dir_req[6].pos_y = 32'sh8000_0000;
    dir_req[6].radius = 29'h1FFF_FFFF;
    dir_req[7] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[7].pos_x = 32'sh8000_0000; dir_req[7].pos_y = 32'sh7FFF_FFFF;
    // clear, then query finds nothing
    dir_req[8] = blank_req(tht_pkg::MODE_CLEAR);
    dir_typed[8] = 1'b1;
    dir_req[9] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[9].radius = 29'h1FFF_FFFF;
    dir_typed[9] = 1'b1;
    // small quad and queries just inside and just outside its edge
    dir_req[10] = blank_req(tht_pkg::MODE_APPEND);
    dir_req[10].entity_id = 32'd77; dir_req[10].scale_x = 31'd131072;
    dir_req[10].scale_y = 31'd131072;
    dir_req[11] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[11].pos_x = 32'sd32768 + 32'sd65536; dir_req[11].pos_y = 32'sd32768;
    dir_req[12] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[12].pos_x = 32'sd32768 + 32'sd65537; dir_req[12].pos_y = 32'sd32768;
    dir_req[13] = blank_req(tht_pkg::MODE_QUERY);
    dir_req[13].pos_x = 32'sd32768 + 32'sd65537; dir_req[13].pos_y = 32'sd32768;
    dir_req[13].radius = 29'd1;
  endtask

  initial begin
    touch_req_t r;
    hit_result_t none;
    errors = 0; calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = tht_pkg::MODE_NOP;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    count_mdl = 0;
    cam_x_mdl = 0; cam_y_mdl = 0; zoom_mdl = 31'd65536;
    half_w_mdl = 29'd32768; half_h_mdl = 29'd32768; min_half_mdl = 29'd0;
    none = '{1'b0, 32'd0, 1'b0, 7'd0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    build_directed();
    for (int i = 0; i < N_DIRECTED; i++) send_request(dir_req[i], dir_typed[i], dir_res[i]);
    drain_results();

    // fill the table past its end
    for (int i = 0; i < tht_pkg::MAX_QUADS + 2; i++) begin
      r = random_req(1'b0);
      r.mode = tht_pkg::MODE_APPEND;
      send_request(r, 1'b0, none);
    end
    drain_results();

    // random phases under several camera settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_camera(32'd0, 32'd0, 32'd65536, 32'd32768 * 1280, 32'd32768 * 720, 32'd0);
        1: set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'd268435456, 32'd268435456, 32'd268435456);
        2: set_camera(32'd0, 32'd0, 32'd0, 32'd32768, 32'd32768, 32'd65536 * 10);
        3: set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd32768, 32'd268435456, 32'd0);
        4: set_camera($urandom, $urandom, $urandom_range(32'h7FFF_FFFF, 1),
                      $urandom_range(268435456, 32768), $urandom_range(268435456, 32768),
                      $urandom_range(268435456));
        default: set_camera($urandom_range(65536 * 8), $urandom_range(65536 * 8),
                            $urandom_range(65536 * 64, 1), 32'd65536 * 200,
                            32'd65536 * 200, $urandom_range(65536 * 4));
      endcase
      calm = (ph == 3);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        r = random_req($urandom_range(9) == 0);
        send_request(r, 1'b0, none);
      end
      calm = 1'b0;
      drain_results();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
